@@ rtl/core/mpa_pkg.sv @@
`timescale 1ns / 1ps
// Package for the multi-pattern automaton: default sizes, opcodes and status codes.
// Used by multi_pattern_automaton_top; depends on nothing.
package mpa_pkg;

  localparam int MAX_NODES_DEF     = 1024;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int VALUE_BITS_DEF    = 16;

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_Z = 8'h7a;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_SCAN  = 2'd2;
  localparam logic [1:0] OP_ROOT  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd2;
  localparam logic [2:0] ST_AFTER_BLD = 3'd3;
  localparam logic [2:0] ST_NOT_BUILT = 3'd4;

endpackage

@@ rtl/core/multi_pattern_automaton_top.sv @@
`timescale 1ns / 1ps
// Top level of the multi-pattern automaton: trie build, link build and scanning.
// Depends on mpa_pkg. The tables live in internal single-port-read memories.
//
// Usage. Each accepted input item gives exactly one result item. An item is
// accepted when in_valid_i is high and in_stall_o is low; a result is taken
// when out_valid_o is high and out_stall_i is low. The block works on one item
// at a time and in_stall_o is high while an item is in progress.
// After reset the block runs a clearing pass over the child table and the node
// values, during which in_stall_o stays high.
// Errors, builds after the first and root resets go straight to S_RESP; an add
// or a scan first passes through the states AD0 to AD3 or SC0 to SC3, a chain
// of dependent memory reads on the child or goto table.
// The first build walks every node once in breadth-first order, reading its fail
// link and values, then one child-table read and goto write per letter.
// A stalled result holds in the output register; the next item may be accepted
// meanwhile and its result waits until the register is free.
module multi_pattern_automaton_top
  import mpa_pkg::*;
#(
  parameter int MaxNodes     = MAX_NODES_DEF,
  parameter int AlphabetSize = ALPHABET_SIZE_DEF,
  parameter int ValueBits    = VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  char_code_i,
  input  logic        pattern_end_i,
  input  logic [7:0]  weight_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [9:0]  node_index_o,
  output logic [15:0] match_value_o
);

  localparam int NodeW   = $clog2(MaxNodes);
  localparam int CntW    = $clog2(MaxNodes + 1);
  localparam int LetW    = (AlphabetSize > 1) ? $clog2(AlphabetSize) : 1;
  localparam int TabSize = MaxNodes * AlphabetSize;
  localparam int TabW    = $clog2(TabSize);
  localparam int unsigned AlphaU = AlphabetSize;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_SC0  = 5'd2;
  localparam logic [4:0] S_SC1  = 5'd3;
  localparam logic [4:0] S_SC2  = 5'd4;
  localparam logic [4:0] S_SC3  = 5'd5;
  localparam logic [4:0] S_AD0  = 5'd6;
  localparam logic [4:0] S_AD1  = 5'd7;
  localparam logic [4:0] S_AD2  = 5'd8;
  localparam logic [4:0] S_AD3  = 5'd9;
  localparam logic [4:0] S_QRD  = 5'd10;
  localparam logic [4:0] S_FRD  = 5'd11;
  localparam logic [4:0] S_VRD  = 5'd12;
  localparam logic [4:0] S_VWR  = 5'd13;
  localparam logic [4:0] S_LRD  = 5'd14;
  localparam logic [4:0] S_LWR  = 5'd15;
  localparam logic [4:0] S_RESP = 5'd16;

  logic [NodeW-1:0]     child_mem [TabSize];
  logic [NodeW-1:0]     goto_mem  [TabSize];
  logic [NodeW-1:0]     fail_mem  [MaxNodes];
  logic [ValueBits-1:0] val_mem   [MaxNodes];
  logic [NodeW-1:0]     queue_mem [MaxNodes];

  logic                 child_we, goto_we, fail_we, val_we, queue_we;
  logic [TabW-1:0]      child_wa, child_ra, goto_wa, goto_ra;
  logic [NodeW-1:0]     child_wd, goto_wd, fail_wa, fail_wd, fail_ra;
  logic [NodeW-1:0]     val_wa, val_ra, queue_wa, queue_wd, queue_ra;
  logic [ValueBits-1:0] val_wd;
  logic [NodeW-1:0]     child_rd, goto_rd, fail_rd, queue_rd;
  logic [ValueBits-1:0] val_rd;

  logic [4:0]           state_q, state_d;
  logic [TabW-1:0]      clr_q, clr_d;
  logic [LetW-1:0]      let_q, let_d, l_q, l_d;
  logic                 pend_q, pend_d, built_q, built_d;
  logic [7:0]           w_q, w_d;
  logic [TabW-1:0]      addr_q, addr_d, ubase_q, ubase_d, fbase_q, fbase_d;
  logic [NodeW-1:0]     node_q, node_d, cursor_q, cursor_d, scan_q, scan_d, u_q, u_d;
  logic [CntW-1:0]      count_q, count_d, head_q, head_d, tail_q, tail_d;
  logic [ValueBits-1:0] vu_q, vu_d;
  logic [2:0]           res_status_q, res_status_d;
  logic [NodeW-1:0]     res_node_q, res_node_d;
  logic [ValueBits-1:0] res_val_q, res_val_d;
  logic                 out_valid_q, out_valid_d;
  logic [2:0]           out_status_q, out_status_d;
  logic [9:0]           out_node_q, out_node_d;
  logic [15:0]          out_val_q, out_val_d;

  logic [7:0]           let_off;
  logic                 let_ok;
  logic [LetW-1:0]      let_idx;
  logic [ValueBits:0]   sum;
  logic [ValueBits-1:0] sat_sum;
  logic [NodeW-1:0]     fsel, fnext;

  assign let_off = char_code_i - CHAR_A;
  assign let_ok  = (char_code_i >= CHAR_A) && (char_code_i <= CHAR_Z)
                   && (32'(let_off) < AlphaU);
  assign let_idx = LetW'(let_off);

  always_comb begin
    if (state_q == S_AD3) begin
      sum = {1'b0, val_rd} + {1'b0, ValueBits'(w_q)};
    end else begin
      sum = {1'b0, vu_q} + {1'b0, val_rd};
    end
    sat_sum = sum[ValueBits] ? {ValueBits{1'b1}} : sum[ValueBits-1:0];
  end

  assign fsel  = (u_q == '0) ? '0 : fail_rd;
  assign fnext = (u_q == '0) ? '0 : goto_rd;

  always_comb begin
    state_d = state_q;  clr_d = clr_q;      let_d = let_q;    l_d = l_q;
    pend_d = pend_q;    built_d = built_q;  w_d = w_q;        addr_d = addr_q;
    ubase_d = ubase_q;  fbase_d = fbase_q;  node_d = node_q;  cursor_d = cursor_q;
    scan_d = scan_q;    u_d = u_q;          count_d = count_q;
    head_d = head_q;    tail_d = tail_q;    vu_d = vu_q;
    res_status_d = res_status_q;  res_node_d = res_node_q;  res_val_d = res_val_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_status_d = out_status_q;  out_node_d = out_node_q;  out_val_d = out_val_q;
    child_we = 1'b0;  child_wa = addr_q;  child_wd = '0;  child_ra = addr_q;
    goto_we = 1'b0;   goto_wa = ubase_q + TabW'(l_q);  goto_wd = '0;
    goto_ra = addr_q;
    fail_we = 1'b0;   fail_wa = child_rd;  fail_wd = fnext;  fail_ra = queue_rd;
    val_we = 1'b0;    val_wa = node_q;  val_wd = sat_sum;  val_ra = node_q;
    queue_we = 1'b0;  queue_wa = tail_q[NodeW-1:0];  queue_wd = child_rd;
    queue_ra = head_q[NodeW-1:0];
    in_stall_o = (state_q != S_IDLE);

    unique case (state_q)
      S_CLR: begin
        child_we = 1'b1;
        child_wa = clr_q;
        if (32'(clr_q) < MaxNodes) begin
          val_we = 1'b1;
          val_wa = NodeW'(clr_q);
          val_wd = '0;
        end
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == TabSize - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          let_d = let_idx;
          pend_d = pattern_end_i;
          w_d = weight_i;
          res_status_d = ST_OK;
          res_node_d = '0;
          res_val_d = '0;
          state_d = S_RESP;
          unique case (opcode_i)
            OP_ADD: begin
              res_node_d = cursor_q;
              if (built_q) begin
                res_status_d = ST_AFTER_BLD;
              end else if (!let_ok) begin
                res_status_d = ST_BAD_CHAR;
              end else begin
                state_d = S_AD0;
              end
            end
            OP_BUILD: begin
              if (!built_q) begin
                queue_we = 1'b1;
                queue_wa = '0;
                queue_wd = '0;
                head_d = '0;
                tail_d = CntW'(1);
                state_d = S_QRD;
              end
            end
            OP_SCAN: begin
              res_node_d = scan_q;
              if (!built_q) begin
                res_status_d = ST_NOT_BUILT;
              end else if (!let_ok) begin
                res_status_d = ST_BAD_CHAR;
              end else begin
                state_d = S_SC0;
              end
            end
            OP_ROOT: begin
              scan_d = '0;
            end
          endcase
        end
      end
      S_SC0: begin
        addr_d = TabW'(32'(scan_q) * AlphaU) + TabW'(let_q);
        state_d = S_SC1;
      end
      S_SC1: begin
        goto_ra = addr_q;
        state_d = S_SC2;
      end
      S_SC2: begin
        scan_d = goto_rd;
        res_node_d = goto_rd;
        val_ra = goto_rd;
        state_d = S_SC3;
      end
      S_SC3: begin
        res_val_d = val_rd;
        state_d = S_RESP;
      end
      S_AD0: begin
        addr_d = TabW'(32'(cursor_q) * AlphaU) + TabW'(let_q);
        state_d = S_AD1;
      end
      S_AD1: begin
        child_ra = addr_q;
        state_d = S_AD2;
      end
      S_AD2: begin
        if (child_rd == '0) begin
          if (32'(count_q) >= MaxNodes) begin
            res_status_d = ST_FULL;
            state_d = S_RESP;
          end else begin
            child_we = 1'b1;
            child_wd = NodeW'(count_q);
            node_d = NodeW'(count_q);
            val_ra = NodeW'(count_q);
            count_d = count_q + 1'b1;
            state_d = S_AD3;
          end
        end else begin
          node_d = child_rd;
          val_ra = child_rd;
          state_d = S_AD3;
        end
      end
      S_AD3: begin
        res_node_d = node_q;
        if (pend_q) begin
          val_we = 1'b1;
          val_wa = node_q;
          val_wd = sat_sum;
          res_val_d = sat_sum;
          cursor_d = '0;
        end else begin
          res_val_d = val_rd;
          cursor_d = node_q;
        end
        state_d = S_RESP;
      end
      S_QRD: begin
        queue_ra = head_q[NodeW-1:0];
        head_d = head_q + 1'b1;
        state_d = S_FRD;
      end
      S_FRD: begin
        u_d = queue_rd;
        ubase_d = TabW'(32'(queue_rd) * AlphaU);
        fail_ra = queue_rd;
        val_ra = queue_rd;
        state_d = S_VRD;
      end
      S_VRD: begin
        fbase_d = TabW'(32'(fsel) * AlphaU);
        vu_d = val_rd;
        val_ra = fsel;
        state_d = S_VWR;
      end
      S_VWR: begin
        if (u_q != '0) begin
          val_we = 1'b1;
          val_wa = u_q;
          val_wd = sat_sum;
        end
        l_d = '0;
        state_d = S_LRD;
      end
      S_LRD: begin
        child_ra = ubase_q + TabW'(l_q);
        goto_ra = fbase_q + TabW'(l_q);
        state_d = S_LWR;
      end
      S_LWR: begin
        goto_we = 1'b1;
        goto_wa = ubase_q + TabW'(l_q);
        if (child_rd != '0) begin
          goto_wd = child_rd;
          fail_we = 1'b1;
          queue_we = 1'b1;
          tail_d = tail_q + 1'b1;
        end else begin
          goto_wd = fnext;
        end
        if (32'(l_q) == AlphabetSize - 1) begin
          if (head_q == tail_d) begin
            built_d = 1'b1;
            res_status_d = ST_OK;
            res_node_d = '0;
            res_val_d = '0;
            state_d = S_RESP;
          end else begin
            state_d = S_QRD;
          end
        end else begin
          l_d = l_q + 1'b1;
          state_d = S_LRD;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_status_d = res_status_q;
          out_node_d = 10'(res_node_q);
          out_val_d = 16'(res_val_q);
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (child_we) begin
      child_mem[child_wa] <= child_wd;
    end
    child_rd <= child_mem[child_ra];
  end

  always_ff @(posedge clk_i) begin
    if (goto_we) begin
      goto_mem[goto_wa] <= goto_wd;
    end
    goto_rd <= goto_mem[goto_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) begin
      fail_mem[fail_wa] <= fail_wd;
    end
    fail_rd <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    val_rd <= val_mem[val_ra];
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) begin
      queue_mem[queue_wa] <= queue_wd;
    end
    queue_rd <= queue_mem[queue_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      built_q <= 1'b0;
      count_q <= CntW'(1);
      cursor_q <= '0;
      scan_q <= '0;
      head_q <= '0;
      tail_q <= '0;
      l_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      built_q <= built_d;
      count_q <= count_d;
      cursor_q <= cursor_d;
      scan_q <= scan_d;
      head_q <= head_d;
      tail_q <= tail_d;
      l_q <= l_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    let_q <= let_d;
    pend_q <= pend_d;
    w_q <= w_d;
    addr_q <= addr_d;
    ubase_q <= ubase_d;
    fbase_q <= fbase_d;
    node_q <= node_d;
    u_q <= u_d;
    vu_q <= vu_d;
    res_status_q <= res_status_d;
    res_node_q <= res_node_d;
    res_val_q <= res_val_d;
    out_status_q <= out_status_d;
    out_node_q <= out_node_d;
    out_val_q <= out_val_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign node_index_o  = out_node_q;
  assign match_value_o = out_val_q;

endmodule
